@@ rtl/bitmap_slot_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap slot allocator assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk_i, off during reset
`define BSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap slot allocator: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap slot allocator: next-cycle check failed");

`else

`define BSA_ASSERT_NOW(lbl, ante, cons)
`define BSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// shared sizes, codes, sequencer states and request types of the allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsa_pkg;

  // pool geometry
  localparam int SLOTS       = 64;
  localparam int MAX_BLOCKS  = 16;
  localparam int TOTAL_SLOTS = SLOTS * MAX_BLOCKS;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SLOT_CNT_W = $clog2(SLOTS + 1);
  localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int ACT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int TFS_W      = $clog2(TOTAL_SLOTS + 1);

  // field widths
  localparam int SIZE_W   = 13;
  localparam int OFF_W    = 22;
  localparam int STAT_W   = 2;
  localparam int LIVE_W   = 11;
  localparam int BYTES_W  = 23;
  localparam int SIZE_MAX = 4096;
  localparam int SIZE_RST = 16;

  // shared multiplier
  localparam int MUL_A_W = TFS_W;
  localparam int MUL_P_W = MUL_A_W + SIZE_W;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_SLOT_SIZE = '0;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DOUBLE    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_DIV,
    S_FREE,
    S_MUL_RES,
    S_MUL_TOT,
    S_MUL_FREE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
  } mul_req_t;

endpackage

@@ rtl/bsa_div.sv @@
// ----------------------------------------------------------------------------
// bsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_div import bsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OFF_W-1:0]  dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [OFF_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OFF_W-1:0]  quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dvs_q, dvs_d;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[OFF_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(OFF_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the low bits
      rem_d = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quo_d = {quo_q[OFF_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/bsa_mul.sv @@
// ----------------------------------------------------------------------------
// bsa_mul
// shared registered multiplier for byte offsets and byte counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_mul import bsa_pkg::*; (
  input  logic               clk_i,
  input  mul_req_t           req_i,
  input  logic [SIZE_W-1:0]  size_i,
  output logic [MUL_P_W-1:0] prod_o
);

  logic [MUL_P_W-1:0] prod_q, prod_d;

  always_comb begin
    prod_d = prod_q;
    if (req_i.en) begin
      prod_d = MUL_P_W'(req_i.a) * MUL_P_W'(size_i);
    end
  end

  // product holds while no new request is issued
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/bitmap_slot_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// fixed-size object pool with a free bitmap and a free count per block
// ----------------------------------------------------------------------------
// The pool is a row of up to 16 blocks of 64 slots, each slot as many bytes
// as the size register gives (0 reads as 1, above 4096 as 4096). One request
// is worked at a time and the input stalls until its result is in the output
// register; the next request is taken while that result waits. An allocate
// scans past full blocks newest block first, one free count checked per
// cycle; an exhausted pool passes all 16 blocks and skips the slot update. A
// free waits for the serial divider that turns the byte offset into block and
// slot at one quotient bit per cycle. Result offset and byte counts come from
// one shared multiplier. No clearing pass: the bitmaps and counts are
// flip-flops reset at once.
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_top_macros.svh"

module bitmap_slot_allocator_top import bsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [OFF_W-1:0]   offset_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [OFF_W-1:0]   result_offset_o,
  output logic [LIVE_W-1:0]  live_objects_o,
  output logic [BYTES_W-1:0] pool_bytes_o,
  output logic [BYTES_W-1:0] spare_bytes_o
);

  localparam int QB_W  = OFF_W - SLOT_W;
  localparam int SUM_W = TFS_W + 1;

  // lowest set bit by halving the window, one level per slot index bit
  function automatic logic [SLOT_W-1:0] lowest_free(input logic [SLOTS-1:0] map);
    logic [SLOTS-1:0]  m;
    logic [SLOTS-1:0]  lo_mask;
    logic [SLOT_W-1:0] idx;
    m   = map;
    idx = '0;
    for (int lvl = SLOT_W - 1; lvl >= 0; lvl--) begin
      lo_mask = (SLOTS'(1) << (1 << lvl)) - SLOTS'(1);
      if ((m & lo_mask) == '0) begin
        idx[lvl] = 1'b1;
        m        = m >> (1 << lvl);
      end
    end
    return idx;
  endfunction

  // configuration register
  logic [SIZE_W-1:0] obj_size_q, obj_size_d;
  logic              cfg_wr;
  logic [SIZE_W-1:0] eff_size;

  // sequencer and pool state
  state_e                state_q, state_d;
  logic [SLOTS-1:0]      map_q [MAX_BLOCKS];
  logic [SLOTS-1:0]      map_d [MAX_BLOCKS];
  logic [SLOT_CNT_W-1:0] cnt_q [MAX_BLOCKS];
  logic [SLOT_CNT_W-1:0] cnt_d [MAX_BLOCKS];
  logic [ACT_W-1:0]      act_q, act_d;
  logic [LIVE_W-1:0]     live_q, live_d;
  logic [TFS_W-1:0]      tfs_q, tfs_d;

  // per-request working registers
  logic [ACT_W-1:0]   scan_q, scan_d;
  logic [ACT_W-1:0]   scan_m1;
  logic [BLK_W-1:0]   tgt_q, tgt_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [MUL_A_W-1:0] res_op_q, res_op_d;
  logic [OFF_W-1:0]   res_off_q, res_off_d;
  logic [BYTES_W-1:0] tot_q, tot_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  o_status_q, o_status_d;
  logic [OFF_W-1:0]   o_off_q, o_off_d;
  logic [LIVE_W-1:0]  o_live_q, o_live_d;
  logic [BYTES_W-1:0] o_tot_q, o_tot_d;
  logic [BYTES_W-1:0] o_free_q, o_free_d;

  // sequencer outputs
  logic     in_acc;
  logic     div_start;
  logic     out_load;
  mul_req_t mul_req;

  // shared units
  logic               div_done;
  logic [OFF_W-1:0]   quot;
  logic [MUL_P_W-1:0] prod;
  logic [QB_W-1:0]    q_blk;
  logic [SLOT_W-1:0]  q_slot;
  logic [SLOT_W-1:0]  lo_slot;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SLOT_SIZE);

  always_comb begin
    obj_size_d = obj_size_q;
    if (cfg_wr) begin
      obj_size_d = pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_SLOT_SIZE) begin
      prdata = DATA_W'(obj_size_q);
    end
  end

  // zero size counts as one, oversize clamps to the largest slot
  always_comb begin
    if (obj_size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (obj_size_q > SIZE_W'(SIZE_MAX)) begin
      eff_size = SIZE_W'(SIZE_MAX);
    end else begin
      eff_size = obj_size_q;
    end
  end

  // ---------------------------------------------------------------- units
  bsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset_i),
    .divisor_i  (eff_size),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  bsa_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .size_i (size_q),
    .prod_o (prod)
  );

  // quotient splits into block number and slot in block
  assign q_blk   = quot[OFF_W-1:SLOT_W];
  assign q_slot  = quot[SLOT_W-1:0];
  assign scan_m1 = scan_q - 1'b1;
  assign lo_slot = lowest_free(map_q[tgt_q]);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = mode_i ? S_DIV : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (scan_q == '0) begin
          // no active block has room: open a new one if the limit allows
          state_d = (act_q < ACT_W'(MAX_BLOCKS)) ? S_ALLOC : S_MUL_RES;
        end else if (cnt_q[scan_m1[BLK_W-1:0]] != '0) begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC:    state_d = S_MUL_RES;
      S_DIV: begin
        if (div_done) begin
          state_d = S_FREE;
        end
      end
      S_FREE:     state_d = S_MUL_RES;
      S_MUL_RES:  state_d = S_MUL_TOT;
      S_MUL_TOT:  state_d = S_MUL_FREE;
      S_MUL_FREE: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    mul_req    = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_valid_i && mode_i;
      end
      S_MUL_RES: begin
        mul_req.en = 1'b1;
        mul_req.a  = res_op_q;
      end
      S_MUL_TOT: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'({act_q, SLOT_W'(0)});
      end
      S_MUL_FREE: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(tfs_q);
      end
      S_OUT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- datapath
  always_comb begin
    map_d     = map_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    live_d    = live_q;
    tfs_d     = tfs_q;
    scan_d    = scan_q;
    tgt_d     = tgt_q;
    size_d    = size_q;
    status_d  = status_q;
    res_op_d  = res_op_q;
    res_off_d = res_off_q;
    tot_d     = tot_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // size is latched so a request sees one value from start to end
          size_d   = eff_size;
          status_d = ST_OK;
          res_op_d = '0;
          scan_d   = act_q;
        end
      end
      S_SEARCH: begin
        if (scan_q == '0) begin
          if (act_q < ACT_W'(MAX_BLOCKS)) begin
            tgt_d = act_q[BLK_W-1:0];
            act_d = act_q + 1'b1;
            tfs_d = tfs_q + TFS_W'(SLOTS);
          end else begin
            status_d = ST_EXHAUSTED;
          end
        end else if (cnt_q[scan_m1[BLK_W-1:0]] != '0) begin
          tgt_d = scan_m1[BLK_W-1:0];
        end else begin
          scan_d = scan_m1;
        end
      end
      S_ALLOC: begin
        map_d[tgt_q][lo_slot] = 1'b0;
        cnt_d[tgt_q]          = cnt_q[tgt_q] - 1'b1;
        tfs_d                 = tfs_q - 1'b1;
        live_d                = live_q + 1'b1;
        res_op_d              = MUL_A_W'({tgt_q, lo_slot});
      end
      S_FREE: begin
        if (32'(q_blk) >= 32'(act_q)) begin
          status_d = ST_OUTSIDE;
        end else if (map_q[q_blk[BLK_W-1:0]][q_slot]) begin
          status_d = ST_DOUBLE;
        end else begin
          map_d[q_blk[BLK_W-1:0]][q_slot] = 1'b1;
          cnt_d[q_blk[BLK_W-1:0]]         = cnt_q[q_blk[BLK_W-1:0]] + 1'b1;
          tfs_d                           = tfs_q + 1'b1;
          live_d                          = live_q - 1'b1;
        end
      end
      S_MUL_TOT:  res_off_d = prod[OFF_W-1:0];
      S_MUL_FREE: tot_d     = prod[BYTES_W-1:0];
      default: begin
        tgt_d = tgt_q;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    o_status_d  = o_status_q;
    o_off_d     = o_off_q;
    o_live_d    = o_live_q;
    o_tot_d     = o_tot_q;
    o_free_d    = o_free_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      o_status_d  = status_q;
      o_off_d     = res_off_q;
      o_live_d    = live_q;
      o_tot_d     = tot_q;
      o_free_d    = prod[BYTES_W-1:0];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_size_q  <= SIZE_W'(SIZE_RST);
      state_q     <= S_IDLE;
      act_q       <= '0;
      live_q      <= '0;
      tfs_q       <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        map_q[b] <= '1;
        cnt_q[b] <= SLOT_CNT_W'(SLOTS);
      end
    end else begin
      obj_size_q  <= obj_size_d;
      state_q     <= state_d;
      act_q       <= act_d;
      live_q      <= live_d;
      tfs_q       <= tfs_d;
      out_valid_q <= out_valid_d;
      map_q       <= map_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    tgt_q      <= tgt_d;
    size_q     <= size_d;
    status_q   <= status_d;
    res_op_q   <= res_op_d;
    res_off_q  <= res_off_d;
    tot_q      <= tot_d;
    o_status_q <= o_status_d;
    o_off_q    <= o_off_d;
    o_live_q   <= o_live_d;
    o_tot_q    <= o_tot_d;
    o_free_q   <= o_free_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign result_offset_o = o_off_q;
  assign live_objects_o  = o_live_q;
  assign pool_bytes_o    = o_tot_q;
  assign spare_bytes_o   = o_free_q;

  // ---------------------------------------------------------------- assertions
  // between requests every slot of an active block is either live or free
  `BSA_ASSERT_NOW(a_slot_balance, state_q == S_IDLE, (SUM_W'(live_q) + SUM_W'(tfs_q)) == SUM_W'({act_q, SLOT_W'(0)}))
  // exhaustion is only reported with every block active
  `BSA_ASSERT_NOW(a_exhausted_full, out_load && (status_q == ST_EXHAUSTED), act_q == ACT_W'(MAX_BLOCKS))
  // the divider only finishes while the sequencer waits for it
  `BSA_ASSERT_NOW(a_div_done_state, div_done, state_q == S_DIV)
  // a result load always goes back to taking requests
  `BSA_ASSERT_NEXT(a_load_to_idle, out_load, state_q == S_IDLE && out_valid_q)

endmodule
